// ===== sv/apai_pkg.sv =====
// Shared widths, codes and state types of the averaged profile angle interpolator.
package apai_pkg;

	localparam int unsigned OPCODE_W  = 2;
	localparam int unsigned ROW_IDX_W = 6;
	localparam int unsigned COL_IDX_W = 8;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned ANGLE_W   = 16;
	localparam int unsigned INTENS_W  = 32;
	localparam int unsigned HCOUNT_W  = 7;
	localparam int unsigned VCOUNT_W  = 9;

	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;

	// A column sum over at most 127 rows of 32-bit samples.
	localparam int unsigned SUM_W = INTENS_W + HCOUNT_W;
	// Product of an average and an angle difference, and the sum of two of them.
	localparam int unsigned MUL_W = INTENS_W + ANGLE_W;
	localparam int unsigned NUM_W = MUL_W + 1;
	// Serial divider: dividend, divisor and step counter widths.
	localparam int unsigned DVD_W  = NUM_W;
	localparam int unsigned DVS_W  = ANGLE_W;
	localparam int unsigned DCNT_W = $clog2(DVD_W + 1);

	localparam logic [OPCODE_W-1:0] OP_WR_ANGLE  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_WR_SAMPLE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_QUERY     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HORZ_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_COUNT = 8'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SUM,
		ST_DIV,
		ST_MUL_A,
		ST_MUL_B,
		ST_ADD,
		ST_DONE
	} apai_state_t;

	typedef enum logic [1:0] {
		DU_AVG0,
		DU_AVG1,
		DU_INTERP
	} apai_div_use_t;

endpackage

// ===== sv/apai_ifs.sv =====
// Handshake channel interfaces: command items, result items and configuration writes.
interface apai_cmd_if import apai_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OPCODE_W-1:0]  opcode;
	logic [ROW_IDX_W-1:0] row_index;
	logic [COL_IDX_W-1:0] column_index;
	logic [VALUE_W-1:0]   write_value;
	logic [ANGLE_W-1:0]   query_angle;

	modport source(output valid, opcode, row_index, column_index, write_value, query_angle,
		input ready);
	modport sink(input valid, opcode, row_index, column_index, write_value, query_angle,
		output ready);
endinterface

interface apai_rsp_if import apai_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [INTENS_W-1:0] intensity;
	logic                in_range;

	modport source(output valid, intensity, in_range, input ready);
	modport sink(input valid, intensity, in_range, output ready);
endinterface

interface apai_cfg_if import apai_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/apai_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module apai_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/averaged_profile_angle_interpolator.sv =====
// Top level of the averaged profile angle interpolator.
//
// The block keeps a table of vertical angles (unsigned Q8.8 degrees, sorted
// ascending by the user) and a grid of intensity samples (unsigned Q20.12),
// one row per horizontal angle and one column per vertical angle, in two
// synchronous memories. Write beats on the command channel load one angle or
// one sample each; writes whose row or column lies beyond the memory size are
// dropped, and the unused opcode is ignored. Both memories come out of reset
// uninitialized and are never cleared, so every entry that a query can reach
// must be written first. A query beat produces exactly one result beat. It
// walks the angle table one entry per cycle to find the first interval that
// holds the query angle, sums the two bounding columns over all active rows
// through the single read port of the sample memory, turns each sum into an
// average with a one-bit-per-cycle divider, and interpolates with two
// multiplications into one product register followed by a final serial
// division. An angle outside every interval returns right after the search.
// The search and the sample memory port set the bulk of the query time. The
// block takes no new command while a query is in progress, but the result
// sits in an output register so the next command is accepted while it waits
// to be taken. Configuration registers take effect on the next query; the
// user must write them only while the block is idle, as the block itself
// does not enforce this.
module averaged_profile_angle_interpolator import apai_pkg::*; #(
	parameter int unsigned MAX_ROWS    = 64,
	parameter int unsigned MAX_COLUMNS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	apai_cfg_if.sink   cfg,
	apai_cmd_if.sink   cmd,
	apai_rsp_if.source rsp
);

	localparam int unsigned COL_W  = $clog2(MAX_COLUMNS);
	localparam int unsigned CNT_W  = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned ADDR_W = $clog2(MAX_ROWS * MAX_COLUMNS);

	// Configuration registers.
	logic [HCOUNT_W-1:0] horz_count_q;
	logic [VCOUNT_W-1:0] vert_count_q;

	// Control state.
	apai_state_t state_q, state_d;
	logic        ang_pend_s1;
	logic        smp_pend_s1;
	logic        rsp_valid_q;

	// Query datapath.
	logic [ANGLE_W-1:0]  q_q;
	logic [ANGLE_W-1:0]  lo_q;
	logic [ANGLE_W-1:0]  hi_q;
	logic [ANGLE_W-1:0]  prev_ang_q;
	logic [COL_W-1:0]    col_q;
	logic                single_q;
	logic [CNT_W-1:0]    srch_idx_q;
	logic [CNT_W-1:0]    ang_idx_s1;
	logic [HCOUNT_W-1:0] row_cnt_q;
	logic [ADDR_W-1:0]   sum_addr_q;
	logic [SUM_W-1:0]    acc_q;
	logic [INTENS_W-1:0] avg0_q;
	logic [INTENS_W-1:0] avg1_q;
	logic [MUL_W-1:0]    mul_q;
	logic [NUM_W-1:0]    num_q;
	logic [DVD_W-1:0]    quo_q;
	logic [DVS_W-1:0]    rem_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	apai_div_use_t       div_use_q;
	logic [INTENS_W-1:0] res_q;
	logic                flag_q;
	logic [INTENS_W-1:0] rsp_intensity_q;
	logic                rsp_in_range_q;

	// Memory ports.
	logic               ang_we;
	logic [COL_W-1:0]   ang_waddr;
	logic [ANGLE_W-1:0] ang_wdata;
	logic [COL_W-1:0]   ang_raddr;
	logic [ANGLE_W-1:0] ang_rdata;
	logic               smp_we;
	logic [ADDR_W-1:0]  smp_waddr;
	logic [VALUE_W-1:0] smp_wdata;
	logic [ADDR_W-1:0]  smp_raddr;
	logic [VALUE_W-1:0] smp_rdata;

	// Derived control.
	logic                cmd_fire;
	logic                cmd_query;
	logic                col_ok;
	logic                row_ok;
	logic [CNT_W-1:0]    cols_eff;
	logic [HCOUNT_W-1:0] rows_eff;
	logic                srch_issue;
	logic                srch_hit;
	logic                srch_last;
	logic                sum_issue;
	logic                sum_done;
	logic                div_busy;
	logic                rsp_load;
	logic [DVS_W:0]      rem_sh;
	logic [DVS_W+1:0]    rem_diff;
	logic                rem_ge;
	logic [DVS_W-1:0]    rem_next;

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd_query = (cmd.opcode == OP_QUERY);
	assign col_ok    = (32'(cmd.column_index) < MAX_COLUMNS);
	assign row_ok    = (32'(cmd.row_index) < MAX_ROWS);

	// Counts above the memory size act as the memory size.
	assign cols_eff = (32'(vert_count_q) > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS)
		: CNT_W'(vert_count_q);
	assign rows_eff = (32'(horz_count_q) > MAX_ROWS) ? HCOUNT_W'(MAX_ROWS) : horz_count_q;

	// The search reads one angle per cycle; the data of index k arrives in the next
	// cycle, when the angle of index k - 1 sits in prev_ang_q.
	assign srch_issue = (srch_idx_q != cols_eff);
	assign srch_hit   = ang_pend_s1 && (ang_idx_s1 != '0) && (q_q >= prev_ang_q)
		&& (q_q < ang_rdata);
	assign srch_last  = ang_pend_s1 && (ang_idx_s1 == cols_eff - CNT_W'(1));

	// Column sums read one row per cycle and add the data in the following cycle.
	assign sum_issue = (row_cnt_q != rows_eff);
	assign sum_done  = !sum_issue && !smp_pend_s1;

	// Restoring division, one quotient bit per cycle. The partial remainder
	// always stays below the divisor, so it fits the divisor width.
	assign div_busy = (div_cnt_q != '0);
	assign rem_sh   = {rem_q, quo_q[DVD_W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign rem_ge   = !rem_diff[DVS_W+1];
	assign rem_next = rem_ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];

	// The finished result moves to the output register once that is free.
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horz_count_q <= '0;
			vert_count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_HORZ_COUNT: horz_count_q <= cfg.data[HCOUNT_W-1:0];
				REG_VERT_COUNT: vert_count_q <= cfg.data[VCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire && cmd_query) begin
					if (rows_eff == '0) begin
						state_d = ST_DONE;
					end else if (cols_eff < CNT_W'(2)) begin
						state_d = ST_SUM;
					end else begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (srch_hit) begin
					state_d = ST_SUM;
				end else if (srch_last) begin
					state_d = ST_DONE;
				end
			end
			ST_SUM: begin
				if (sum_done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					case (div_use_q)
						DU_AVG0:   state_d = single_q ? ST_DONE : ST_SUM;
						DU_AVG1:   state_d = ST_MUL_A;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_ADD;
			ST_ADD:   state_d = ST_DIV;
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and memory port controls.
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		ang_we    = cmd_fire && (cmd.opcode == OP_WR_ANGLE) && col_ok;
		ang_waddr = COL_W'(cmd.column_index);
		ang_wdata = cmd.write_value[ANGLE_W-1:0];
		ang_raddr = COL_W'(srch_idx_q);
		smp_we    = cmd_fire && (cmd.opcode == OP_WR_SAMPLE) && col_ok && row_ok;
		smp_waddr = ADDR_W'(cmd.row_index) * ADDR_W'(MAX_COLUMNS)
			+ ADDR_W'(cmd.column_index);
		smp_wdata = cmd.write_value;
		smp_raddr = sum_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ang_pend_s1 <= 1'b0;
			smp_pend_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ang_pend_s1 <= (state_q == ST_SEARCH) && srch_issue;
			smp_pend_s1 <= (state_q == ST_SUM) && sum_issue;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Query datapath.
	always_ff @(posedge clk) begin
		ang_idx_s1 <= srch_idx_q;
		if (ang_pend_s1) begin
			prev_ang_q <= ang_rdata;
		end
		if (smp_pend_s1) begin
			acc_q <= acc_q + SUM_W'(smp_rdata);
		end
		case (state_q)
			ST_IDLE: begin
				q_q        <= cmd.query_angle;
				srch_idx_q <= '0;
				col_q      <= '0;
				single_q   <= (cols_eff < CNT_W'(2));
				row_cnt_q  <= '0;
				sum_addr_q <= '0;
				acc_q      <= '0;
				div_cnt_q  <= '0;
				div_use_q  <= DU_AVG0;
				res_q      <= '0;
				flag_q     <= 1'b0;
			end
			ST_SEARCH: begin
				if (srch_issue) begin
					srch_idx_q <= srch_idx_q + CNT_W'(1);
				end
				if (srch_hit) begin
					col_q      <= COL_W'(ang_idx_s1 - CNT_W'(1));
					sum_addr_q <= ADDR_W'(ang_idx_s1 - CNT_W'(1));
					lo_q       <= prev_ang_q;
					hi_q       <= ang_rdata;
				end
			end
			ST_SUM: begin
				if (sum_issue) begin
					row_cnt_q  <= row_cnt_q + HCOUNT_W'(1);
					sum_addr_q <= sum_addr_q + ADDR_W'(MAX_COLUMNS);
				end
				if (sum_done) begin
					// Pre-shift the sum so only its own bits take divider steps.
					quo_q     <= {acc_q, {(DVD_W - SUM_W){1'b0}}};
					rem_q     <= '0;
					dvs_q     <= DVS_W'(rows_eff);
					div_cnt_q <= DCNT_W'(SUM_W);
				end
			end
			ST_DIV: begin
				if (div_busy) begin
					quo_q     <= {quo_q[DVD_W-2:0], rem_ge};
					rem_q     <= rem_next;
					div_cnt_q <= div_cnt_q - DCNT_W'(1);
				end else begin
					case (div_use_q)
						DU_AVG0: begin
							avg0_q <= quo_q[INTENS_W-1:0];
							if (single_q) begin
								res_q  <= quo_q[INTENS_W-1:0];
								flag_q <= 1'b1;
							end else begin
								div_use_q  <= DU_AVG1;
								row_cnt_q  <= '0;
								acc_q      <= '0;
								sum_addr_q <= ADDR_W'(col_q) + ADDR_W'(1);
							end
						end
						DU_AVG1: begin
							avg1_q <= quo_q[INTENS_W-1:0];
						end
						default: begin
							res_q  <= quo_q[INTENS_W-1:0];
							flag_q <= 1'b1;
						end
					endcase
				end
			end
			ST_MUL_A: begin
				// Weight of the lower column is the distance to the upper angle.
				mul_q <= MUL_W'(avg0_q) * MUL_W'(hi_q - q_q);
			end
			ST_MUL_B: begin
				num_q <= NUM_W'(mul_q);
				mul_q <= MUL_W'(avg1_q) * MUL_W'(q_q - lo_q);
			end
			ST_ADD: begin
				quo_q     <= num_q + NUM_W'(mul_q);
				rem_q     <= '0;
				dvs_q     <= hi_q - lo_q;
				div_cnt_q <= DCNT_W'(DVD_W);
				div_use_q <= DU_INTERP;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_intensity_q <= res_q;
			rsp_in_range_q  <= flag_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.intensity = rsp_intensity_q;
	assign rsp.in_range  = rsp_in_range_q;

	apai_ram #(
		.WIDTH(ANGLE_W),
		.DEPTH(MAX_COLUMNS)
	) u_angle_ram (
		.clk  (clk),
		.we   (ang_we),
		.waddr(ang_waddr),
		.wdata(ang_wdata),
		.raddr(ang_raddr),
		.rdata(ang_rdata)
	);

	apai_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_ROWS * MAX_COLUMNS)
	) u_sample_ram (
		.clk  (clk),
		.we   (smp_we),
		.waddr(smp_waddr),
		.wdata(smp_wdata),
		.raddr(smp_raddr),
		.rdata(smp_rdata)
	);

endmodule

// ===== sv/apai_checker.sv =====
// Port-level assertions for the interpolator and the bind that attaches them.
module apai_checker import apai_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic [OPCODE_W-1:0] cmd_opcode,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [INTENS_W-1:0] rsp_intensity,
	input logic                rsp_in_range
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_intensity) && $stable(rsp_in_range))
		else $error("result payload changed while stalled");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_in_range |-> rsp_intensity == '0)
		else $error("out-of-range result carries a nonzero intensity");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_opcode == OP_QUERY |=> !cmd_ready)
		else $error("command taken right after a query beat");

endmodule

bind averaged_profile_angle_interpolator apai_checker u_apai_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.cmd_opcode   (cmd.opcode),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_intensity(rsp.intensity),
	.rsp_in_range (rsp.in_range)
);

// ===== tb/averaged_profile_angle_interpolator_test.sv =====
// Self-checking testbench for the averaged profile angle interpolator.
module averaged_profile_angle_interpolator_test;
	import apai_pkg::*;

	localparam int unsigned ROWS = 64;
	localparam int unsigned COLS = 256;

	// The fourth opcode has no meaning; the block must swallow it without a result beat.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	// Register indexes past the two real registers must leave both untouched.
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 8'hFF;

	typedef struct {
		logic [OPCODE_W-1:0]  opcode;
		logic [ROW_IDX_W-1:0] row;
		logic [COL_IDX_W-1:0] col;
		logic [VALUE_W-1:0]   value;
		logic [ANGLE_W-1:0]   angle;
	} profile_cmd_t;

	typedef struct packed {
		logic [INTENS_W-1:0] intensity;
		logic                in_range;
	} profile_result_t;

	logic clk;
	logic arst_n;

	apai_cfg_if cfg_ch();
	apai_cmd_if cmd_ch();
	apai_rsp_if rsp_ch();

	averaged_profile_angle_interpolator #(
		.MAX_ROWS(ROWS),
		.MAX_COLUMNS(COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// Shadow copy of the block: both registers, the angle table and the sample grid.
	// It is updated at the rising edge on which the matching beat is accepted.
	logic [HCOUNT_W-1:0] rows_reg;
	logic [VCOUNT_W-1:0] cols_reg;
	logic [ANGLE_W-1:0]  angle_mem [COLS];
	logic [VALUE_W-1:0]  sample_mem [ROWS*COLS];

	// Command beats waiting for the driver, and results that queries have earned.
	profile_cmd_t    pending_cmds [$];
	profile_result_t expected_profiles [$];

	// Angles as the stimulus side has planned them, used to aim queries at the table.
	logic [ANGLE_W-1:0] planned_angles [COLS];
	int unsigned planned_span;

	int unsigned issued_cmds;
	int unsigned accepted_cmds;
	int unsigned random_items;
	int unsigned mismatches;

	// Handshake flags seen at the last rising edge, consumed at the following falling edge.
	logic cmd_fired;
	logic rsp_fired;
	logic cfg_fired;
	int unsigned cmd_gap;
	int unsigned rsp_stall;
	bit calm_cmd;
	bit calm_rsp;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// A run is only allowed so long; a hung handshake ends here as a failure.
	initial begin : watchdog
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Average of one column over the active rows, rounded down.
	function automatic logic [INTENS_W-1:0] column_mean(int unsigned col, int unsigned rows);
		logic [63:0] total;
		total = '0;
		for (int r = 0; r < rows; r++)
			total += sample_mem[r*COLS + col];
		return total / rows;
	endfunction

	// What a query beat must return, given the shadow state at the moment it is accepted.
	function automatic profile_result_t interpolate_profile(logic [ANGLE_W-1:0] q);
		profile_result_t res;
		int unsigned rows;
		int unsigned cols;
		int unsigned span_idx;
		logic [63:0] avg0;
		logic [63:0] avg1;
		logic [63:0] width;
		logic [63:0] offset;
		bit found;
		res = '0;
		// Counts past the memory size behave as the memory size.
		rows = (rows_reg > ROWS) ? ROWS : rows_reg;
		cols = (cols_reg > COLS) ? COLS : cols_reg;
		if (rows == 0)
			return res;
		// With fewer than two angles there is nothing to interpolate between.
		if (cols < 2) begin
			res.intensity = column_mean(0, rows);
			res.in_range  = 1'b1;
			return res;
		end
		found    = 1'b0;
		span_idx = 0;
		for (int i = 0; i + 1 < cols && !found; i++) begin
			if (q >= angle_mem[i] && q < angle_mem[i+1]) begin
				found    = 1'b1;
				span_idx = i;
			end
		end
		if (!found)
			return res;
		// A bracketing interval always has a nonzero width, so the division is safe.
		avg0   = column_mean(span_idx, rows);
		avg1   = column_mean(span_idx + 1, rows);
		width  = angle_mem[span_idx+1] - angle_mem[span_idx];
		offset = q - angle_mem[span_idx];
		res.intensity = (avg0 * (width - offset) + avg1 * offset) / width;
		res.in_range  = 1'b1;
		return res;
	endfunction

	// Monitor: everything is sampled at the rising edge. Results are checked before the
	// command of the same edge is applied, so a fresh query never meets its own result.
	always @(posedge clk) begin : watch
		profile_result_t want;
		cmd_fired <= arst_n && cmd_ch.valid && cmd_ch.ready;
		rsp_fired <= arst_n && rsp_ch.valid && rsp_ch.ready;
		cfg_fired <= arst_n && cfg_ch.valid && cfg_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_profiles.size() == 0) begin
				report_mismatch("result beat with no query waiting", rsp_ch.intensity, '0);
			end else begin
				want = expected_profiles.pop_front();
				if (rsp_ch.intensity !== want.intensity)
					report_mismatch("intensity", rsp_ch.intensity, want.intensity);
				if (rsp_ch.in_range !== want.in_range)
					report_mismatch("in_range", rsp_ch.in_range, want.in_range);
			end
		end
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			if (cfg_ch.index == REG_HORZ_COUNT)
				rows_reg = cfg_ch.data[HCOUNT_W-1:0];
			else if (cfg_ch.index == REG_VERT_COUNT)
				cols_reg = cfg_ch.data[VCOUNT_W-1:0];
		end
		// Row and column indexes cannot exceed the memory size at these widths.
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			accepted_cmds++;
			case (cmd_ch.opcode)
				OP_WR_ANGLE: begin
					angle_mem[cmd_ch.column_index] = cmd_ch.write_value[ANGLE_W-1:0];
				end
				OP_WR_SAMPLE: begin
					sample_mem[cmd_ch.row_index*COLS + cmd_ch.column_index] = cmd_ch.write_value;
				end
				OP_QUERY: begin
					expected_profiles.push_back(interpolate_profile(cmd_ch.query_angle));
				end
				default: begin
				end
			endcase
		end
	end

	function automatic int unsigned next_gap(bit calm);
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	// Command driver: presents one queued beat at a time at the falling edge and holds it
	// until it is taken, then idles for the gap drawn for that beat.
	always @(negedge clk) begin : feed
		profile_cmd_t item;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_fired) begin
			if (cmd_gap > 0) begin
				cmd_ch.valid <= 1'b0;
				cmd_gap <= cmd_gap - 1;
			end else if (pending_cmds.size() != 0) begin
				item = pending_cmds.pop_front();
				cmd_ch.valid        <= 1'b1;
				cmd_ch.opcode       <= item.opcode;
				cmd_ch.row_index    <= item.row;
				cmd_ch.column_index <= item.col;
				cmd_ch.write_value  <= item.value;
				cmd_ch.query_angle  <= item.angle;
				cmd_gap <= next_gap(calm_cmd);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: stalls after each taken beat for a drawn number of cycles, and now and
	// then drops ready on its own so that results also arrive into a stalled receiver.
	always @(negedge clk) begin : take
		int unsigned stall;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (rsp_fired) begin
			stall = next_gap(calm_rsp);
			rsp_ch.ready <= (stall == 0);
			rsp_stall <= (stall == 0) ? 0 : stall - 1;
		end else if (rsp_stall > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall <= rsp_stall - 1;
		end else if (!calm_rsp && $urandom_range(0, 7) == 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall <= $urandom_range(0, 8);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= word;
		do @(negedge clk); while (!cfg_fired);
		cfg_ch.valid <= 1'b0;
	endtask

	// Register word with random bits above the field, which the block must ignore.
	function automatic logic [CFG_DATA_W-1:0] reg_word(int unsigned value, int unsigned width);
		return ($urandom() << width) | value;
	endfunction

	// Holds the sender back until every beat is taken and every result has come.
	// Writes give no result, so a further wait lets the last of them settle.
	task automatic wait_idle();
		while (accepted_cmds != issued_cmds || expected_profiles.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic push_cmd(input logic [OPCODE_W-1:0] op, input int unsigned row,
		input int unsigned col, input logic [VALUE_W-1:0] value, input logic [ANGLE_W-1:0] angle);
		profile_cmd_t item;
		item.opcode = op;
		item.row    = row;
		item.col    = col;
		item.value  = value;
		item.angle  = angle;
		pending_cmds.push_back(item);
		issued_cmds++;
	endtask

	// Fields that an opcode does not use carry random bits.
	task automatic push_angle(input int unsigned col, input logic [ANGLE_W-1:0] angle);
		planned_angles[col] = angle;
		push_cmd(OP_WR_ANGLE, $urandom(), col, {$urandom_range(0, 65535), angle}, $urandom());
	endtask

	task automatic push_sample(input int unsigned row, input int unsigned col,
		input logic [VALUE_W-1:0] value);
		push_cmd(OP_WR_SAMPLE, row, col, value, $urandom());
	endtask

	task automatic push_query(input logic [ANGLE_W-1:0] angle);
		push_cmd(OP_QUERY, $urandom(), $urandom(), $urandom(), angle);
	endtask

	task automatic push_unused();
		push_cmd(OP_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
	endtask

	function automatic logic [VALUE_W-1:0] sample_value();
		case ($urandom_range(0, 7))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	// Query angles cluster on table entries and just either side of them, where the
	// interval search makes its decisions, with some spread anywhere and at the ends.
	function automatic logic [ANGLE_W-1:0] pick_angle();
		int unsigned j;
		j = $urandom_range(0, planned_span - 1);
		case ($urandom_range(0, 6))
			0: return planned_angles[j];
			1: return planned_angles[j] - 1;
			2: return planned_angles[j] + 1;
			3: return planned_angles[j] + $urandom_range(0, 63);
			4: return $urandom_range(0, 65535);
			5: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// Writes every angle and sample that a query under this setting can reach. Sorted
	// tables step upward by random amounts, sometimes by zero to make empty intervals,
	// and pile up at full scale near the end when the steps run out of room.
	task automatic load_table(input int unsigned rows, input int unsigned cols, input bit sorted);
		int unsigned span;
		int unsigned step_max;
		int unsigned a;
		span     = (cols < 2) ? 2 : cols;
		step_max = 131070 / span;
		a        = $urandom_range(0, 255);
		for (int c = 0; c < span; c++) begin
			if (!sorted)
				a = $urandom_range(0, 65535);
			else if (c != 0 && $urandom_range(0, 7) != 0)
				a = a + $urandom_range(1, step_max);
			if (a > 65535)
				a = 65535;
			push_angle(c, a[ANGLE_W-1:0]);
		end
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < ((cols < 1) ? 1 : cols); c++)
				push_sample(r, c, sample_value());
	endtask

	// One setting of the registers: program them while idle, optionally reload the
	// memories, then mostly queries with overwrites and unused opcodes mixed in.
	task automatic run_phase(input int unsigned h_word, input int unsigned v_word,
		input bit reload, input int unsigned items, input bit mid_pause);
		int unsigned rows;
		int unsigned cols;
		int unsigned sel;
		rows = (h_word > ROWS) ? ROWS : h_word;
		cols = (v_word > COLS) ? COLS : v_word;
		calm_cmd = ($urandom_range(0, 3) == 0);
		calm_rsp = ($urandom_range(0, 3) == 0);
		write_reg(REG_HORZ_COUNT, reg_word(h_word, HCOUNT_W));
		write_reg(REG_VERT_COUNT, reg_word(v_word, VCOUNT_W));
		if (reload)
			load_table(rows, cols, $urandom_range(0, 3) != 0);
		planned_span = (cols < 2) ? 2 : cols;
		for (int k = 0; k < items; k++) begin
			if (mid_pause && k == items / 2)
				wait_idle();
			sel = $urandom_range(0, 19);
			if (sel < 13)
				push_query(pick_angle());
			else if (sel < 16)
				push_sample($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
					sample_value());
			else if (sel < 19)
				push_angle($urandom_range(0, planned_span - 1), $urandom_range(0, 65535));
			else
				push_unused();
			if (sel < 19)
				random_items++;
		end
		wait_idle();
	endtask

	initial begin : stimulus
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.opcode       = '0;
		cmd_ch.row_index    = '0;
		cmd_ch.column_index = '0;
		cmd_ch.write_value  = '0;
		cmd_ch.query_angle  = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		rsp_ch.ready        = 1'b0;
		cmd_fired           = 1'b0;
		rsp_fired           = 1'b0;
		cfg_fired           = 1'b0;
		cmd_gap             = 0;
		rsp_stall           = 0;
		calm_cmd            = 1'b0;
		calm_rsp            = 1'b0;
		rows_reg            = '0;
		cols_reg            = '0;
		issued_cmds         = 0;
		accepted_cmds       = 0;
		random_items        = 0;
		mismatches          = 0;
		planned_span        = 2;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Two rows and four angles with a repeated angle, so the table holds an empty
		// interval, and samples at zero and at full scale so that the column sums and
		// the interpolation products reach their widest values.
		write_reg(REG_HORZ_COUNT, reg_word(2, HCOUNT_W));
		write_reg(REG_VERT_COUNT, reg_word(4, VCOUNT_W));
		push_angle(0, 16'h0000);
		push_angle(1, 16'h0100);
		push_angle(2, 16'h0100);
		push_angle(3, 16'hFFFF);
		push_sample(0, 0, 32'hFFFF_FFFF);
		push_sample(0, 1, 32'h0);
		push_sample(0, 2, $urandom());
		push_sample(0, 3, 32'hFFFF_FFFF);
		push_sample(1, 0, 32'hFFFF_FFFF);
		push_sample(1, 1, 32'hFFFF_FFFF);
		push_sample(1, 2, $urandom());
		push_sample(1, 3, 32'h0);
		// Lower edge, middle and top of the first interval; the repeated angle, which
		// skips the empty interval and lands in the next one; just under and exactly at
		// the top angle, which is outside every interval.
		push_query(16'h0000);
		push_query(16'h0080);
		push_query(16'h00FF);
		push_query(16'h0100);
		push_query(16'hFFFE);
		push_query(16'hFFFF);
		push_unused();
		wait_idle();

		// One angle and then none fall back to the average of the first column.
		write_reg(REG_VERT_COUNT, reg_word(1, VCOUNT_W));
		push_query($urandom_range(0, 65535));
		wait_idle();
		write_reg(REG_VERT_COUNT, reg_word(0, VCOUNT_W));
		push_query($urandom_range(0, 65535));
		wait_idle();
		// No rows gives zero with the flag clear, and writes to unknown registers
		// must not bring the rows back.
		write_reg(REG_HORZ_COUNT, reg_word(0, HCOUNT_W));
		push_query($urandom_range(0, 65535));
		wait_idle();
		write_reg(REG_FIRST_UNUSED, $urandom());
		write_reg(REG_LAST_UNUSED, $urandom());
		push_query($urandom_range(0, 65535));
		wait_idle();

		// Extreme settings: every row, every column, oversized counts in both registers
		// (the widest column count reuses the full table just loaded), and no rows.
		run_phase(64, 2, 1'b1, 14, 1'b1);
		run_phase(1, 256, 1'b1, 12, 1'b0);
		run_phase(1, 511, 1'b0, 10, 1'b0);
		run_phase(127, 3, 1'b1, 14, 1'b0);
		run_phase(0, 7, 1'b1, 8, 1'b0);
		// Small random settings keep queries short while the contents vary widely.
		while (random_items < 400)
			run_phase($urandom_range(1, 6), $urandom_range(0, 10), 1'b1,
				$urandom_range(8, 20), $urandom_range(0, 5) == 0);

		repeat (48) @(negedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
